### rtl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and constants for the handheld bus decoder with cartridge
// bank controller.
// ----------------------------------------------------------------------------
package hbd_pkg;

    // default geometry of the cartridge
    localparam int DEF_ROM_BANKS = 64;
    localparam int DEF_RAM_BANKS = 4;

    // field widths
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int LCD_W    = 2;
    localparam int REGION_W = 4;
    localparam int OFFS_W   = 20;
    localparam int MODE_W   = 2;

    // cartridge controller selection
    typedef enum logic [MODE_W-1:0] {
        CART_ROM_ONLY = 2'd0,
        CART_MBC1     = 2'd1,
        CART_MBC3     = 2'd2,
        CART_SPARE    = 2'd3
    } t_cart_mode;

    // target region of a request
    typedef enum logic [REGION_W-1:0] {
        RGN_ROM      = 4'd0,
        RGN_VRAM     = 4'd1,
        RGN_CART_RAM = 4'd2,
        RGN_WRAM     = 4'd3,
        RGN_OAM      = 4'd4,
        RGN_UNUSABLE = 4'd5,
        RGN_IO       = 4'd6,
        RGN_HRAM     = 4'd7,
        RGN_IE       = 4'd8,
        RGN_BANK_REG = 4'd9
    } t_region;

    // bank register slots in the rom window
    localparam logic [1:0] SLOT_RAM_EN   = 2'd0;
    localparam logic [1:0] SLOT_ROM_BANK = 2'd1;
    localparam logic [1:0] SLOT_RAM_BANK = 2'd2;
    localparam logic [1:0] SLOT_BANK_MOD = 2'd3;

    // address map boundaries
    localparam logic [ADDR_W-1:0] ADDR_ROMX     = 16'h4000;
    localparam logic [ADDR_W-1:0] ADDR_VRAM     = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_CART_RAM = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_WRAM     = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_ECHO     = 16'hE000;
    localparam logic [ADDR_W-1:0] ADDR_OAM      = 16'hFE00;
    localparam logic [ADDR_W-1:0] ADDR_UNUSABLE = 16'hFEA0;
    localparam logic [ADDR_W-1:0] ADDR_IO       = 16'hFF00;
    localparam logic [ADDR_W-1:0] ADDR_HRAM     = 16'hFF80;
    localparam logic [ADDR_W-1:0] ADDR_IE       = 16'hFFFF;

    // command codes and constant bytes
    localparam logic              CMD_READ     = 1'b0;
    localparam logic              CMD_WRITE    = 1'b1;
    localparam logic [DATA_W-1:0] RAM_EN_KEY   = 8'h0A;
    localparam logic [DATA_W-1:0] CART_RAM_OFF = 8'hFF;
    localparam logic [DATA_W-1:0] UNUSABLE_VAL = 8'h00;
    localparam logic [LCD_W-1:0]  LCD_OAM_SCAN = 2'd2;

endpackage

### rtl/handheld_bus_decoder_mbc_unit.sv
// ----------------------------------------------------------------------------
// handheld_bus_decoder_mbc_unit
// Decodes one cpu bus request per cycle unless the output stalls, into region,
// banked offset and take/constant flags; keeps the cartridge bank registers.
// ----------------------------------------------------------------------------
//
//  channel  handshake                  payload
//  -------  -------------------------  ----------------------------------------
//  in       i_in_valid / o_in_ready    i_command i_address i_write_data
//                                      i_lcd_mode
//  out      o_out_valid / i_out_ready  o_region o_physical_offset
//                                      o_access_taken o_constant_read
//                                      o_constant_value
//  cfg      i_cfg_we                   i_cfg_data (cart mode)
//
//  one request per cycle sustained while the output is not stalled; a request
//  passes through the input register, then is decoded into the result register
//  bank registers are loaded when the write leaves the input register,
//  so the next request already sees them
//  synchronous active-low reset clears valids, mode, ram regs; rom bank is one
//  a stalled output holds the input register, which then drops o_in_ready
//
module handheld_bus_decoder_mbc_unit
    import hbd_pkg::*;
#(
    parameter int ROM_BANKS = DEF_ROM_BANKS,
    parameter int RAM_BANKS = DEF_RAM_BANKS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [MODE_W-1:0]   i_cfg_data,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [ADDR_W-1:0]   i_address,
    input  logic [DATA_W-1:0]   i_write_data,
    input  logic [LCD_W-1:0]    i_lcd_mode,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [REGION_W-1:0] o_region,
    output logic [OFFS_W-1:0]   o_physical_offset,
    output logic                o_access_taken,
    output logic                o_constant_read,
    output logic [DATA_W-1:0]   o_constant_value
);

    localparam int ROM_BW = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
    localparam int RAM_BW = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
    localparam int TBL_N  = 1 << DATA_W;

    // configuration and bank state
    t_cart_mode          r_cart_mode;
    logic [ROM_BW-1:0]   r_rom_bank;     // effective switchable bank
    logic [RAM_BW-1:0]   r_ram_bank;     // ram bank select, wrapped
    logic                r_ram_en;       // enable word equals the key
    logic                r_mode_zero;    // banking mode word is zero
    logic [ROM_BW-1:0]   n_rom_bank;
    logic [RAM_BW-1:0]   n_ram_bank;
    logic                n_ram_en;
    logic                n_mode_zero;

    // input register
    logic                r_in_valid;
    logic                r_in_cmd;
    logic [ADDR_W-1:0]   r_in_addr;
    logic [DATA_W-1:0]   r_in_data;
    logic [LCD_W-1:0]    r_in_lcd;

    // result register
    logic                r_out_valid;
    t_region             r_region;
    logic [OFFS_W-1:0]   r_offset;
    logic                r_taken;
    logic                r_cread;
    logic [DATA_W-1:0]   r_cval;
    t_region             n_region;
    logic [OFFS_W-1:0]   n_offset;
    logic                n_taken;
    logic                n_cread;
    logic [DATA_W-1:0]   n_cval;

    logic                w_advance;
    logic [ROM_BW-1:0]   w_rom_mod [TBL_N];
    logic [RAM_BW-1:0]   w_ram_mod [TBL_N];

    // modulo tables for the bank counts
    for (genvar g = 0; g < TBL_N; g++) begin : g_mod_tbl
        assign w_rom_mod[g] = ROM_BW'(g % ROM_BANKS);
        assign w_ram_mod[g] = RAM_BW'(g % RAM_BANKS);
    end

    // handshake
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_cmd  <= i_command;
            r_in_addr <= i_address;
            r_in_data <= i_write_data;
            r_in_lcd  <= i_lcd_mode;
        end
    end

    // decode and bank register update
    always_comb begin
        logic              is_mbc1;
        logic              is_mbc3;
        logic              is_wr;
        logic              take_reg;
        logic [1:0]        slot;
        logic [DATA_W-1:0] rom_idx;
        logic [ROM_BW-1:0] romx_bank;
        logic [RAM_BW-1:0] cram_bank;
        logic [21:0]       rom_full;
        logic [16:0]       ram_full;

        is_mbc1   = (r_cart_mode == CART_MBC1);
        is_mbc3   = (r_cart_mode == CART_MBC3);
        is_wr     = (r_in_cmd == CMD_WRITE);
        slot      = r_in_addr[14:13];
        take_reg  = is_mbc1 || (is_mbc3 && slot != SLOT_BANK_MOD);
        rom_idx   = (r_in_data == '0) ? DATA_W'(1) : r_in_data;
        romx_bank = (is_mbc1 || is_mbc3) ? r_rom_bank : w_rom_mod[1];
        cram_bank = (is_mbc1 && r_mode_zero) ? '0 : r_ram_bank;
        rom_full  = {8'(romx_bank), r_in_addr[13:0]};
        ram_full  = {4'(cram_bank), r_in_addr[12:0]};

        n_rom_bank  = r_rom_bank;
        n_ram_bank  = r_ram_bank;
        n_ram_en    = r_ram_en;
        n_mode_zero = r_mode_zero;

        n_region = RGN_ROM;
        n_offset = '0;
        n_taken  = 1'b1;
        n_cread  = 1'b0;
        n_cval   = '0;

        if (r_in_addr < ADDR_VRAM) begin
            if (is_wr) begin
                // bank register load
                n_region = RGN_BANK_REG;
                n_offset = OFFS_W'(slot);
                n_taken  = take_reg;
                if (take_reg && w_advance) begin
                    case (slot)
                        SLOT_RAM_EN:   n_ram_en    = (r_in_data == RAM_EN_KEY);
                        SLOT_ROM_BANK: n_rom_bank  = w_rom_mod[rom_idx];
                        SLOT_RAM_BANK: n_ram_bank  = w_ram_mod[r_in_data];
                        SLOT_BANK_MOD: n_mode_zero = (r_in_data == '0);
                        default:       n_mode_zero = r_mode_zero;
                    endcase
                end
            end else if (r_in_addr < ADDR_ROMX) begin
                n_offset = OFFS_W'(r_in_addr);
            end else begin
                n_offset = rom_full[OFFS_W-1:0];
            end
        end else if (r_in_addr < ADDR_CART_RAM) begin
            n_region = RGN_VRAM;
            n_offset = OFFS_W'(r_in_addr - ADDR_VRAM);
        end else if (r_in_addr < ADDR_WRAM) begin
            // cart ram, constant 0xff when disabled
            n_region = RGN_CART_RAM;
            if ((is_mbc1 || is_mbc3) && r_ram_en) begin
                n_offset = OFFS_W'(ram_full);
            end else begin
                n_offset = OFFS_W'(r_in_addr - ADDR_CART_RAM);
                n_taken  = 1'b0;
                n_cread  = !is_wr;
                n_cval   = is_wr ? '0 : CART_RAM_OFF;
            end
        end else if (r_in_addr < ADDR_ECHO) begin
            n_region = RGN_WRAM;
            n_offset = OFFS_W'(r_in_addr - ADDR_WRAM);
        end else if (r_in_addr < ADDR_OAM) begin
            n_region = RGN_WRAM;
            n_offset = OFFS_W'(r_in_addr - ADDR_ECHO);
        end else if (r_in_addr < ADDR_UNUSABLE) begin
            // oam writes blocked during scan and transfer
            n_region = RGN_OAM;
            n_offset = OFFS_W'(r_in_addr - ADDR_OAM);
            n_taken  = !is_wr || (r_in_lcd < LCD_OAM_SCAN);
        end else if (r_in_addr < ADDR_IO) begin
            n_region = RGN_UNUSABLE;
            n_offset = OFFS_W'(r_in_addr - ADDR_UNUSABLE);
            n_taken  = 1'b0;
            n_cread  = !is_wr;
            n_cval   = UNUSABLE_VAL;
        end else if (r_in_addr < ADDR_HRAM) begin
            n_region = RGN_IO;
            n_offset = OFFS_W'(r_in_addr - ADDR_IO);
        end else if (r_in_addr < ADDR_IE) begin
            n_region = RGN_HRAM;
            n_offset = OFFS_W'(r_in_addr - ADDR_HRAM);
        end else begin
            n_region = RGN_IE;
        end
    end

    // bank state and cart mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_mode <= CART_ROM_ONLY;
            r_rom_bank  <= w_rom_mod[1];
            r_ram_bank  <= '0;
            r_ram_en    <= 1'b0;
            r_mode_zero <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_cart_mode <= t_cart_mode'(i_cfg_data);
            end
            r_rom_bank  <= n_rom_bank;
            r_ram_bank  <= n_ram_bank;
            r_ram_en    <= n_ram_en;
            r_mode_zero <= n_mode_zero;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_region <= n_region;
            r_offset <= n_offset;
            r_taken  <= n_taken;
            r_cread  <= n_cread;
            r_cval   <= n_cval;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_region          = r_region;
    assign o_physical_offset = r_offset;
    assign o_access_taken    = r_taken;
    assign o_constant_read   = r_cread;
    assign o_constant_value  = r_cval;

`ifndef NO_ASSERTIONS
    // a constant read never also touches storage
    a_cread_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_constant_read |-> !o_access_taken)
        else $error("constant read with access taken");

    // constant byte is zero unless it is returned
    a_cval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_constant_read |-> o_constant_value == '0)
        else $error("constant value set without constant read");

    // rom-only cartridges never load a bank register
    a_rom_only_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_cart_mode == CART_ROM_ONLY && o_region == RGN_BANK_REG
        |-> !o_access_taken)
        else $error("bank register loaded in rom-only mode");

    // a held request keeps its address while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_addr))
        else $error("input register lost a stalled request");

    // bank registers only change when a request moves on
    a_bank_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_rom_bank) && $stable(r_ram_bank))
        else $error("bank register changed without a request");
`endif

endmodule

### tb/tb_handheld_bus_decoder_mbc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handheld_bus_decoder_mbc_unit
// Drives cpu bus requests through the decoder under every cartridge mode,
// predicts region, banked offset and take/constant flags from a private copy
// of the bank registers, and checks each result in order.
// ----------------------------------------------------------------------------

// one decoded result as seen on the result channel
typedef struct packed {
    hbd_pkg::t_region        region;
    logic [hbd_pkg::OFFS_W-1:0] offset;
    logic                    taken;
    logic                    cread;
    logic [hbd_pkg::DATA_W-1:0] cval;
} t_bus_decode;

// decode predictor and in-order result checker
class bus_decode_scoreboard;
    hbd_pkg::t_cart_mode cart_mode;
    logic [7:0]          rom_bank_sel;
    logic [7:0]          ram_enable_word;
    logic [7:0]          ram_bank_sel;
    logic [7:0]          banking_mode_word;
    t_bus_decode         expected_decodes[$];
    int                  error_count;

    function new();
        cart_mode         = hbd_pkg::CART_ROM_ONLY;
        rom_bank_sel      = '0;
        ram_enable_word   = '0;
        ram_bank_sel      = '0;
        banking_mode_word = '0;
        error_count       = 0;
    endfunction

    function void set_cart_mode(hbd_pkg::t_cart_mode mode);
        cart_mode = mode;
    endfunction

    function int pending();
        return expected_decodes.size();
    endfunction

    // predict the decode of an accepted request and update the bank registers
    function void note_request(logic cmd, logic [15:0] addr, logic [7:0] data,
                               logic [1:0] lcd);
        t_bus_decode d;
        bit          is_write;
        bit          is_mbc1;
        bit          banked;
        int unsigned bank;
        d        = '0;
        is_write = (cmd == hbd_pkg::CMD_WRITE);
        is_mbc1  = (cart_mode == hbd_pkg::CART_MBC1);
        banked   = is_mbc1 || (cart_mode == hbd_pkg::CART_MBC3);
        if (addr < hbd_pkg::ADDR_VRAM) begin
            if (is_write) begin
                // rom window write loads a bank register slot
                d.region = hbd_pkg::RGN_BANK_REG;
                d.offset = 20'(addr[14:13]);
                d.taken  = is_mbc1 || (banked && addr[14:13] != hbd_pkg::SLOT_BANK_MOD);
                if (d.taken) begin
                    case (addr[14:13])
                        hbd_pkg::SLOT_RAM_EN:   ram_enable_word   = data;
                        hbd_pkg::SLOT_ROM_BANK: rom_bank_sel      = data;
                        hbd_pkg::SLOT_RAM_BANK: ram_bank_sel      = data;
                        default:                banking_mode_word = data;
                    endcase
                end
            end else if (addr < hbd_pkg::ADDR_ROMX) begin
                d.region = hbd_pkg::RGN_ROM;
                d.offset = 20'(addr);
                d.taken  = 1'b1;
            end else begin
                // switchable bank, zero selects bank one, wraps on bank count
                bank = 1;
                if (banked && rom_bank_sel != 0) bank = 32'(rom_bank_sel);
                bank     = bank % hbd_pkg::DEF_ROM_BANKS;
                d.region = hbd_pkg::RGN_ROM;
                d.offset = 20'(bank * 32'h4000 + 32'(addr[13:0]));
                d.taken  = 1'b1;
            end
        end else if (addr < hbd_pkg::ADDR_CART_RAM) begin
            d.region = hbd_pkg::RGN_VRAM;
            d.offset = 20'(addr - hbd_pkg::ADDR_VRAM);
            d.taken  = 1'b1;
        end else if (addr < hbd_pkg::ADDR_WRAM) begin
            d.region = hbd_pkg::RGN_CART_RAM;
            if (banked && ram_enable_word == hbd_pkg::RAM_EN_KEY) begin
                bank = 32'(ram_bank_sel) % hbd_pkg::DEF_RAM_BANKS;
                if (is_mbc1 && banking_mode_word == 0) bank = 0;
                d.offset = 20'(bank * 32'h2000 + 32'(addr - hbd_pkg::ADDR_CART_RAM));
                d.taken  = 1'b1;
            end else begin
                // disabled cart ram reads back all ones
                d.offset = 20'(addr - hbd_pkg::ADDR_CART_RAM);
                d.cread  = !is_write;
                d.cval   = is_write ? 8'h00 : hbd_pkg::CART_RAM_OFF;
            end
        end else if (addr < hbd_pkg::ADDR_ECHO) begin
            d.region = hbd_pkg::RGN_WRAM;
            d.offset = 20'(addr - hbd_pkg::ADDR_WRAM);
            d.taken  = 1'b1;
        end else if (addr < hbd_pkg::ADDR_OAM) begin
            // echo mirrors work ram
            d.region = hbd_pkg::RGN_WRAM;
            d.offset = 20'(addr - hbd_pkg::ADDR_ECHO);
            d.taken  = 1'b1;
        end else if (addr < hbd_pkg::ADDR_UNUSABLE) begin
            d.region = hbd_pkg::RGN_OAM;
            d.offset = 20'(addr - hbd_pkg::ADDR_OAM);
            d.taken  = !is_write || lcd < hbd_pkg::LCD_OAM_SCAN;
        end else if (addr < hbd_pkg::ADDR_IO) begin
            d.region = hbd_pkg::RGN_UNUSABLE;
            d.offset = 20'(addr - hbd_pkg::ADDR_UNUSABLE);
            d.cread  = !is_write;
            d.cval   = hbd_pkg::UNUSABLE_VAL;
        end else if (addr < hbd_pkg::ADDR_HRAM) begin
            d.region = hbd_pkg::RGN_IO;
            d.offset = 20'(addr - hbd_pkg::ADDR_IO);
            d.taken  = 1'b1;
        end else if (addr < hbd_pkg::ADDR_IE) begin
            d.region = hbd_pkg::RGN_HRAM;
            d.offset = 20'(addr - hbd_pkg::ADDR_HRAM);
            d.taken  = 1'b1;
        end else begin
            d.region = hbd_pkg::RGN_IE;
            d.taken  = 1'b1;
        end
        expected_decodes.push_back(d);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic [3:0] region, logic [19:0] offset, logic taken,
                               logic cread, logic [7:0] cval);
        t_bus_decode want;
        if (expected_decodes.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected result: region %0d offset %05h", region, offset);
            return;
        end
        want = expected_decodes.pop_front();
        if (region !== want.region || offset !== want.offset || taken !== want.taken ||
            cread !== want.cread || cval !== want.cval) begin
            error_count++;
            if (error_count <= 10)
                $display("decode mismatch (exp/act): region %0d/%0d offset %05h/%05h %s",
                         want.region, region, want.offset, offset,
                         $sformatf("taken %0d/%0d cread %0d/%0d cval %02h/%02h",
                                   want.taken, taken, want.cread, cread, want.cval, cval));
        end
    endfunction
endclass

module tb_handheld_bus_decoder_mbc_unit;
    import hbd_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 50;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [MODE_W-1:0]   i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_command;
    logic [ADDR_W-1:0]   i_address;
    logic [DATA_W-1:0]   i_write_data;
    logic [LCD_W-1:0]    i_lcd_mode;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [REGION_W-1:0] o_region;
    logic [OFFS_W-1:0]   o_physical_offset;
    logic                o_access_taken;
    logic                o_constant_read;
    logic [DATA_W-1:0]   o_constant_value;

    bus_decode_scoreboard sb;
    bit                   tx_gaps_on;
    bit                   rx_stalls_on;
    int                   cycle_count;

    handheld_bus_decoder_mbc_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_lcd_mode        (i_lcd_mode),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_region          (o_region),
        .o_physical_offset (o_physical_offset),
        .o_access_taken    (o_access_taken),
        .o_constant_read   (o_constant_read),
        .o_constant_value  (o_constant_value)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // send one request, with an optional gap before it
    task automatic send_request(input logic cmd, input logic [15:0] addr,
                                input logic [7:0] data, input logic [1:0] lcd);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_command    = cmd;
        i_address    = addr;
        i_write_data = data;
        i_lcd_mode   = lcd;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(cmd, addr, data, lcd);
    endtask

    // stop sending and let every outstanding request come back
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // cart mode may only change while nothing is in flight
    task automatic write_cart_mode(input t_cart_mode mode);
        wait_for_drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = mode;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_cart_mode(mode);
    endtask

    // random request, biased toward bank setup and banked windows
    task automatic send_random_request();
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [1:0]  lcd;
        int          pick;
        cmd  = 1'($urandom_range(0, 1));
        addr = 16'($urandom_range(0, 65535));
        data = 8'($urandom_range(0, 255));
        lcd  = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            // bank register load, the enable slot mostly with the key
            cmd     = CMD_WRITE;
            addr[15] = 1'b0;
            if (addr[14:13] == SLOT_RAM_EN && $urandom_range(0, 2) != 0)
                data = RAM_EN_KEY;
            else if (addr[14:13] == SLOT_BANK_MOD && $urandom_range(0, 1) != 0)
                data = 8'h00;
        end else if (pick < 45) begin
            addr = {2'b01, addr[13:0]};
        end else if (pick < 65) begin
            addr = {3'b101, addr[12:0]};
        end else if (pick < 75) begin
            addr = {8'hFE, addr[7:0]};
        end else if (pick < 80) begin
            addr = {8'hFF, addr[7:0]};
        end
        send_request(cmd, addr, data, lcd);
    endtask

    // result side: random stalls, check every accepted result
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_stalls_on ? $urandom_range(0, 5) : 0;
            @(negedge i_clk);
            if (stall != 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_region, o_physical_offset, o_access_taken,
                            o_constant_read, o_constant_value);
        end
    end

    // main stimulus
    initial begin
        t_cart_mode phase_modes [8];
        phase_modes = '{CART_MBC1, CART_MBC3, CART_ROM_ONLY, CART_SPARE,
                        CART_MBC3, CART_MBC1, CART_MBC3, CART_MBC1};
        sb           = new();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_command    = CMD_READ;
        i_address    = '0;
        i_write_data = '0;
        i_lcd_mode   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // rom only: map edges, ignored register loads, constant reads
        write_cart_mode(CART_ROM_ONLY);
        send_request(CMD_READ,  16'h0000, 8'h00, 2'd0);
        send_request(CMD_READ,  16'h7FFF, 8'h00, 2'd0);
        send_request(CMD_WRITE, 16'h0000, 8'h0A, 2'd0);
        send_request(CMD_READ,  16'hA000, 8'h00, 2'd0);
        send_request(CMD_WRITE, 16'hBFFF, 8'hFF, 2'd0);
        send_request(CMD_WRITE, 16'hE000, 8'h5A, 2'd0);
        send_request(CMD_WRITE, 16'hFE9F, 8'h11, 2'd3);
        send_request(CMD_WRITE, 16'hFE00, 8'h22, 2'd1);
        send_request(CMD_READ,  16'hFEA0, 8'h00, 2'd2);
        send_request(CMD_WRITE, 16'hFEFF, 8'h33, 2'd0);
        send_request(CMD_WRITE, 16'hFF80, 8'hFF, 2'd0);
        send_request(CMD_WRITE, 16'hFFFF, 8'hFF, 2'd3);

        // mbc1: enable key, bank zero remap, bank wrap, ram banking mode
        write_cart_mode(CART_MBC1);
        send_request(CMD_WRITE, 16'h1FFF, 8'h0A, 2'd0);
        send_request(CMD_WRITE, 16'h2000, 8'h00, 2'd0);
        send_request(CMD_READ,  16'h4000, 8'h00, 2'd0);
        send_request(CMD_WRITE, 16'h3FFF, 8'hFF, 2'd0);
        send_request(CMD_READ,  16'h7FFF, 8'h00, 2'd0);
        send_request(CMD_WRITE, 16'h4000, 8'h07, 2'd0);
        send_request(CMD_READ,  16'hA000, 8'h00, 2'd0);
        send_request(CMD_WRITE, 16'h6000, 8'h01, 2'd0);
        send_request(CMD_READ,  16'hBFFF, 8'h00, 2'd0);
        send_request(CMD_WRITE, 16'h0000, 8'h0B, 2'd0);
        send_request(CMD_READ,  16'hA000, 8'h00, 2'd0);

        // mbc3: banking mode slot ignored, ram bank used directly
        write_cart_mode(CART_MBC3);
        send_request(CMD_WRITE, 16'h7FFF, 8'h00, 2'd0);
        send_request(CMD_WRITE, 16'h0000, 8'h0A, 2'd0);
        send_request(CMD_READ,  16'hA123, 8'h00, 2'd0);

        // random phases over every mode and idle pattern
        for (int phase = 0; phase < 8; phase++) begin
            write_cart_mode(phase_modes[phase]);
            tx_gaps_on   = phase[0];
            rx_stalls_on = phase[1];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off once until every result is back
                if (phase == 5 && n == PHASE_ITEMS / 2) wait_for_drain();
                send_random_request();
            end
        end

        wait_for_drain();
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
